/* src/sfr_pkg.sv */
// ============================================================================
// sfr_pkg: shared types and constants for the sysex frame receiver
// Holds the byte codes, verdict codes, frame decode state and result types.
// ============================================================================
package sfr_pkg;

    // Default raw frame limit, counting the 0xF0 byte
    localparam int MAX_FRAME_DEF = 256;

    // Decoded bytes kept, counting the two checksum bytes
    localparam int DECODED_CAP = 256;
    localparam int DEC_W       = 9;

    // Most results one packet can cause (one per valid byte)
    localparam int MAX_RESULTS = 3;

    // Result queue depth
    localparam int FIFO_DEPTH  = 4;

    // Framing bytes
    localparam logic [7:0] SYX_START = 8'hF0;
    localparam logic [7:0] SYX_END   = 8'hF7;

    // Code index values that carry bytes
    localparam logic [3:0] CIN_SYX_CONT  = 4'h4;
    localparam logic [3:0] CIN_END_THREE = 4'h7;
    localparam logic [3:0] CIN_END_TWO   = 4'h6;
    localparam logic [3:0] CIN_END_ONE   = 4'h5;

    // Verdict codes
    localparam logic [2:0] VERDICT_OK        = 3'd0;
    localparam logic [2:0] VERDICT_SHORT     = 3'd1;
    localparam logic [2:0] VERDICT_MISMATCH  = 3'd2;
    localparam logic [2:0] VERDICT_OVERFLOW  = 3'd3;
    localparam logic [2:0] VERDICT_ABANDONED = 3'd4;

    // Per-frame decode state (raw byte count is kept apart, its width follows MAX_FRAME)
    typedef struct packed {
        logic [2:0]       group_position;
        logic [6:0]       high_bits;
        logic [DEC_W-1:0] decoded_count;
        logic [15:0]      fold_sum;
        logic [15:0]      sent_sum;
    } frame_state_t;

    // One result item
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_end;
        logic [2:0] verdict;
    } sfr_result_t;

endpackage

/* src/sfr_byte_step.sv */
// ============================================================================
// sfr_byte_step: one raw byte through the sysex frame decoder
// Framing, 7-bit group unpacking, checksum capture and XOR fold for one byte.
// ============================================================================
module sfr_byte_step
    import sfr_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    localparam int RAW_W    = $clog2(MAX_FRAME + 1)
)
(
    input  logic             byte_valid,
    input  logic [7:0]       data_byte,
    input  logic [RAW_W-1:0] raw_in,
    input  frame_state_t     st_in,
    output logic [RAW_W-1:0] raw_out,
    output frame_state_t     st_out,
    output logic             res_valid,
    output sfr_result_t      res
);

    localparam logic [RAW_W-1:0] RAW_LIMIT = RAW_W'(MAX_FRAME);
    localparam logic [DEC_W-1:0] DEC_CAP   = DEC_W'(DECODED_CAP);

    logic             frame_open;
    logic             raw_full;
    logic [DEC_W-1:0] dec_m2;
    logic [7:0]       plen;
    logic [7:0]       hb_ext;
    logic [2:0]       hb_idx;
    logic [7:0]       data_full;

    // Frame status and payload length
    assign frame_open = (raw_in != '0);
    assign raw_full   = (raw_in >= RAW_LIMIT);
    assign dec_m2     = st_in.decoded_count - DEC_W'(2);
    assign plen       = (st_in.decoded_count >= DEC_W'(2)) ? dec_m2[7:0] : 8'd0;

    // High bit from the group header is ORed onto the raw data byte
    assign hb_ext    = {1'b0, st_in.high_bits};
    assign hb_idx    = st_in.group_position - 3'd1;
    assign data_full = data_byte | {hb_ext[hb_idx], 7'd0};

    // Single byte step
    always_comb
    begin
        raw_out   = raw_in;
        st_out    = st_in;
        res_valid = 1'b0;
        res       = '0;
        if (byte_valid)
        begin
            if (data_byte == SYX_START)
            begin
                // Restart closes any open frame
                if (frame_open)
                begin
                    res_valid         = 1'b1;
                    res.frame_end     = 1'b1;
                    res.payload_index = plen;
                    res.verdict       = raw_full ? VERDICT_OVERFLOW : VERDICT_ABANDONED;
                end
                raw_out = RAW_W'(1);
                st_out  = '0;
            end
            else if (data_byte == SYX_END && frame_open)
            begin
                res_valid         = 1'b1;
                res.frame_end     = 1'b1;
                res.payload_index = plen;
                if (raw_full || st_in.decoded_count > DEC_CAP)
                    res.verdict = VERDICT_OVERFLOW;
                else if (st_in.decoded_count < DEC_W'(3))
                    res.verdict = VERDICT_SHORT;
                else if (st_in.fold_sum != st_in.sent_sum)
                    res.verdict = VERDICT_MISMATCH;
                else
                    res.verdict = VERDICT_OK;
                raw_out = '0;
                st_out  = '0;
            end
            else if (frame_open && !raw_full)
            begin
                raw_out = raw_in + RAW_W'(1);
                if (st_in.group_position == 3'd0)
                begin
                    // Group header: high bits of the next seven bytes
                    st_out.high_bits      = data_byte[6:0];
                    st_out.group_position = 3'd1;
                end
                else
                begin
                    st_out.group_position = (st_in.group_position == 3'd7) ? 3'd0 :
                                            st_in.group_position + 3'd1;
                    if (st_in.decoded_count == DEC_W'(0))
                        st_out.sent_sum[7:0] = data_full;
                    else if (st_in.decoded_count == DEC_W'(1))
                        st_out.sent_sum[15:8] = data_full;
                    else if (st_in.decoded_count < DEC_CAP)
                    begin
                        // Payload byte: fold by parity of its position
                        if (st_in.decoded_count[0])
                            st_out.fold_sum = st_in.fold_sum ^ {data_full, 8'h00};
                        else
                            st_out.fold_sum = st_in.fold_sum ^ {8'h00, data_full};
                        res_valid         = 1'b1;
                        res.payload_byte  = data_full;
                        res.payload_index = dec_m2[7:0];
                    end
                    if (st_in.decoded_count <= DEC_CAP)
                        st_out.decoded_count = st_in.decoded_count + DEC_W'(1);
                end
            end
        end
    end

endmodule

/* src/sfr_frame_decode.sv */
// ============================================================================
// sfr_frame_decode: packet register, three chained byte steps, frame state
// Registers one packet, decodes its valid bytes in one pass, pushes results.
// ============================================================================
module sfr_frame_decode
    import sfr_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    localparam int RAW_W    = $clog2(MAX_FRAME + 1)
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [3:0]                          code_index,
    input  logic [7:0]                          first_byte,
    input  logic [7:0]                          second_byte,
    input  logic [7:0]                          third_byte,
    input  logic                                space_ok,
    output logic [MAX_RESULTS-1:0]              push_valid,
    output sfr_result_t [MAX_RESULTS-1:0]       push_data
);

    // Number of valid bytes for a code index
    function automatic logic [1:0] byte_count(input logic [3:0] cin);
        logic [1:0] n;
        case (cin)
            CIN_SYX_CONT:  n = 2'd3;
            CIN_END_THREE: n = 2'd3;
            CIN_END_TWO:   n = 2'd2;
            CIN_END_ONE:   n = 2'd1;
            default:       n = 2'd0;
        endcase
        return n;
    endfunction

    logic             pkt_valid_reg;
    logic [1:0]       nbytes_reg;
    logic [7:0]       bytes_reg [MAX_RESULTS];
    logic [RAW_W-1:0] raw_count_reg;
    logic [RAW_W-1:0] raw_count_next;
    frame_state_t     state_reg;
    frame_state_t     state_next;
    logic             fire;
    logic             take;

    logic [RAW_W-1:0] raw_chain [MAX_RESULTS+1];
    frame_state_t     st_chain  [MAX_RESULTS+1];
    logic [MAX_RESULTS-1:0] step_valid;
    sfr_result_t [MAX_RESULTS-1:0] step_res;

    // Handshake: a held packet moves on when the result queue has room
    assign fire     = pkt_valid_reg && space_ok;
    assign in_stall = pkt_valid_reg && !space_ok;
    assign take     = in_valid && !in_stall;

    // Packet register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_valid_reg <= 1'b0;
        end
        else if (take || fire)
        begin
            pkt_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            nbytes_reg   <= byte_count(code_index);
            bytes_reg[0] <= first_byte;
            bytes_reg[1] <= second_byte;
            bytes_reg[2] <= third_byte;
        end
    end

    // Byte steps chained in packet order
    assign raw_chain[0] = raw_count_reg;
    assign st_chain[0]  = state_reg;

    for (genvar i = 0; i < MAX_RESULTS; i++)
    begin : g_step
        sfr_byte_step #(
            .MAX_FRAME (MAX_FRAME)
        ) u_step (
            .byte_valid (nbytes_reg > 2'(i)),
            .data_byte  (bytes_reg[i]),
            .raw_in     (raw_chain[i]),
            .st_in      (st_chain[i]),
            .raw_out    (raw_chain[i+1]),
            .st_out     (st_chain[i+1]),
            .res_valid  (step_valid[i]),
            .res        (step_res[i])
        );
    end

    assign raw_count_next = raw_chain[MAX_RESULTS];
    assign state_next     = st_chain[MAX_RESULTS];
    assign push_valid     = fire ? step_valid : '0;
    assign push_data      = step_res;

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_count_reg <= '0;
            state_reg     <= '0;
        end
        else if (fire)
        begin
            raw_count_reg <= raw_count_next;
            state_reg     <= state_next;
        end
    end

    // Raw count saturates at the frame limit
    a_raw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        raw_count_reg <= RAW_W'(MAX_FRAME))
        else $error("raw count past frame limit");

    // No open frame means cleared decode state
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        raw_count_reg == '0 |->
            (state_reg.group_position == 3'd0 && state_reg.decoded_count == '0 &&
             state_reg.fold_sum == 16'h0000))
        else $error("decode state left over outside a frame");

    // Decoded count stops one past the cap
    a_dec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.decoded_count <= DEC_W'(DECODED_CAP + 1))
        else $error("decoded count past cap");

endmodule

/* src/sfr_result_fifo.sv */
// ============================================================================
// sfr_result_fifo: small result queue
// Takes up to three results a cycle in order, hands out one a cycle unless out_stall holds it.
// ============================================================================
module sfr_result_fifo
    import sfr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [MAX_RESULTS-1:0]        push_valid,
    input  sfr_result_t [MAX_RESULTS-1:0] push_data,
    output logic                          space_ok,
    output logic                          out_valid,
    input  logic                          out_stall,
    output sfr_result_t                   head
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    sfr_result_t       entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [PTR_W-1:0]  wr_off [MAX_RESULTS];
    logic [1:0]        npush;
    logic              pop;

    // Packed write offsets keep results in order
    assign wr_off[0] = '0;
    assign wr_off[1] = PTR_W'(push_valid[0]);
    assign wr_off[2] = PTR_W'(push_valid[0]) + PTR_W'(push_valid[1]);
    assign npush     = {1'b0, push_valid[0]} + {1'b0, push_valid[1]} +
                       {1'b0, push_valid[2]};

    assign out_valid = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign space_ok  = (count_reg <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(npush);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(npush) - CNT_W'(pop);

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry writes
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (push_valid[k])
                entry_reg[wr_ptr_reg + wr_off[k]] <= push_data[k];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(npush) <= CNT_W'(FIFO_DEPTH) - count_reg)
        else $error("results pushed without room");

endmodule

/* src/sysex_frame_receiver.sv */
// ============================================================================
// sysex_frame_receiver: USB-MIDI sysex frame receiver
// Frames 0xF0..0xF7, unpacks 7-bit groups, checks the XOR-fold checksum.
// ============================================================================
// Path: packet register, then result queue, then the output port.
// Throughput: one packet per cycle while each packet yields at most one
// result and the output is not stalled; the output port hands out one
// result per cycle, so packets with two or three results can stall the input.
// Reset: no frame open, decode state cleared, result queue empty.
module sysex_frame_receiver
    import sfr_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] code_index,
    input  logic [7:0] first_byte,
    input  logic [7:0] second_byte,
    input  logic [7:0] third_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic       frame_end,
    output logic [2:0] verdict
);

    logic                          space_ok;
    logic [MAX_RESULTS-1:0]        push_valid;
    sfr_result_t [MAX_RESULTS-1:0] push_data;
    sfr_result_t                   head;

    // Packet decode
    sfr_frame_decode #(
        .MAX_FRAME (MAX_FRAME)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_index  (code_index),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .third_byte  (third_byte),
        .space_ok    (space_ok),
        .push_valid  (push_valid),
        .push_data   (push_data)
    );

    // Result queue
    sfr_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .space_ok   (space_ok),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .head       (head)
    );

    assign payload_byte  = head.payload_byte;
    assign payload_index = head.payload_index;
    assign frame_end     = head.frame_end;
    assign verdict       = head.verdict;

endmodule
